FILE: rtl/pvlfo_pkg.sv
// Shared types, constants and the quarter-wave sine table of the per-voice LFO.
// No dependencies; every other file refers to it by scoped names.
package pvlfo_pkg;

    localparam int VOICES      = 16;
    localparam int VOICE_W     = 4;
    localparam int ADDR_W      = $clog2(VOICES);
    localparam int PHASE_W     = 32;
    localparam int SAMPLE_W    = 16;
    localparam int WAVE_W      = SAMPLE_W + 1;
    localparam int LEVEL_W     = 16;
    localparam int WAVE_SEL_W  = 3;
    localparam int LFSR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int SINE_DEPTH  = 256;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
    localparam int SINE_MAG_W  = 15;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int OCC_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 32'h8020_0003;

    localparam logic [PHASE_W-1:0]    RST_PHASE_INC = 32'd89478;
    localparam logic [WAVE_SEL_W-1:0] RST_WAVEFORM  = 3'd0;
    localparam logic [LEVEL_W-1:0]    RST_LEVEL     = 16'd32768;
    localparam logic [SAMPLE_W-1:0]   RST_OFFSET    = 16'd0;
    localparam logic [LFSR_W-1:0]     RST_SEED      = 32'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_INC  = 3'd0,
        CFG_WAVEFORM   = 3'd1,
        CFG_LEVEL      = 3'd2,
        CFG_OFFSET     = 3'd3,
        CFG_NOISE_SEED = 3'd4
    } cfg_index_t;

    typedef enum logic [WAVE_SEL_W-1:0] {
        WAVE_SINE      = 3'd0,
        WAVE_TRIANGLE  = 3'd1,
        WAVE_SAW_UP    = 3'd2,
        WAVE_SAW_DOWN  = 3'd3,
        WAVE_SQUARE    = 3'd4,
        WAVE_RANDOM    = 3'd5
    } wave_sel_t;

    // Updated voice state handed from the state stage to the shaper
    typedef struct packed {
        logic                valid;
        logic [VOICE_W-1:0]  voice;
        logic [PHASE_W-1:0]  phase;
        logic [SAMPLE_W-1:0] held;
    } phase_stage_t;

    typedef struct packed {
        logic [WAVE_SEL_W-1:0] waveform;
        logic [LEVEL_W-1:0]    level;
        logic [SAMPLE_W-1:0]   offset;
    } shape_cfg_t;

    typedef struct packed {
        logic [VOICE_W-1:0]  voice;
        logic [SAMPLE_W-1:0] mod_value;
    } result_t;

    typedef logic [SINE_MAG_W-1:0] sine_rom_t [SINE_DEPTH];

    // Quarter-wave sine at bin centers, odd Q30 polynomial, rounded to Q15
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] r;
        int          k;
        for (k = 0; k < SINE_DEPTH; k++) begin
            x = (((64'(k) << 1) + 64'd1) << 29) / SINE_DEPTH;
            y = (x * x) >> 30;
            t = 64'd172272;
            t = 64'd5026995    - ((y * t) >> 30);
            t = 64'd85569306   - ((y * t) >> 30);
            t = 64'd693598668  - ((y * t) >> 30);
            t = 64'd1686629713 - ((y * t) >> 30);
            r = (x * t) >> 30;
            r = (r + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            rom[k] = r[SINE_MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/pvlfo_state.sv
// Per-voice state memories (phase, held random) with read-modify-write and forwarding,
// plus the shared noise LFSR. Depends on pvlfo_pkg.
module pvlfo_state (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [pvlfo_pkg::VOICE_W-1:0]      rd_voice,
    input  logic [pvlfo_pkg::PHASE_W-1:0]      phase_inc,
    input  logic                               seed_load,
    input  logic [pvlfo_pkg::LFSR_W-1:0]       seed_value,
    output pvlfo_pkg::phase_stage_t            stage_out
);

    // Voice memories: one read and one write port, read data registered
    logic [pvlfo_pkg::PHASE_W-1:0]  phase_mem [pvlfo_pkg::VOICES];
    logic [pvlfo_pkg::SAMPLE_W-1:0] held_mem  [pvlfo_pkg::VOICES];
    logic [pvlfo_pkg::VOICES-1:0]   written_reg;

    logic [pvlfo_pkg::PHASE_W-1:0]  phase_rd_reg;
    logic [pvlfo_pkg::SAMPLE_W-1:0] held_rd_reg;
    logic                           written_rd_reg;

    logic                           s1_valid_reg;
    logic [pvlfo_pkg::VOICE_W-1:0]  s1_voice_reg;

    logic                           fwd_valid_reg;
    logic [pvlfo_pkg::VOICE_W-1:0]  fwd_voice_reg;
    logic [pvlfo_pkg::PHASE_W-1:0]  fwd_phase_reg;
    logic [pvlfo_pkg::SAMPLE_W-1:0] fwd_held_reg;

    logic [pvlfo_pkg::LFSR_W-1:0]   lfsr_reg;
    logic [pvlfo_pkg::LFSR_W-1:0]   lfsr_next;

    pvlfo_pkg::phase_stage_t        stage_reg;
    pvlfo_pkg::phase_stage_t        stage_next;

    logic                           fwd_hit;
    logic [pvlfo_pkg::PHASE_W-1:0]  phase_cur;
    logic [pvlfo_pkg::SAMPLE_W-1:0] held_cur;
    logic [pvlfo_pkg::PHASE_W:0]    phase_sum;
    logic                           wrap;
    logic [pvlfo_pkg::LFSR_W-1:0]   lfsr_src;
    logic [pvlfo_pkg::LFSR_W-1:0]   lfsr_step;
    logic [pvlfo_pkg::SAMPLE_W-1:0] held_new;

    // Read both memories at the accepted voice
    always_ff @(posedge clk) begin
        if (rd_en) begin
            phase_rd_reg <= phase_mem[rd_voice[pvlfo_pkg::ADDR_W-1:0]];
            held_rd_reg  <= held_mem[rd_voice[pvlfo_pkg::ADDR_W-1:0]];
        end
    end

    // Write back the updated voice state
    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            phase_mem[s1_voice_reg[pvlfo_pkg::ADDR_W-1:0]] <= phase_sum[pvlfo_pkg::PHASE_W-1:0];
            held_mem[s1_voice_reg[pvlfo_pkg::ADDR_W-1:0]]  <= held_new;
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            written_reg    <= '0;
            written_rd_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            lfsr_reg       <= pvlfo_pkg::RST_SEED;
            stage_reg      <= '0;
        end else begin
            if (s1_valid_reg) begin
                written_reg[s1_voice_reg[pvlfo_pkg::ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                written_rd_reg <= written_reg[rd_voice[pvlfo_pkg::ADDR_W-1:0]];
            end
            s1_valid_reg    <= rd_en;
            fwd_valid_reg   <= s1_valid_reg;
            lfsr_reg        <= lfsr_next;
            stage_reg       <= stage_next;
        end
    end

    // Hold voice index and the last write for forwarding; payload needs no reset
    always_ff @(posedge clk) begin
        if (rd_en) begin
            s1_voice_reg <= rd_voice;
        end
        if (s1_valid_reg) begin
            fwd_voice_reg <= s1_voice_reg;
            fwd_phase_reg <= phase_sum[pvlfo_pkg::PHASE_W-1:0];
            fwd_held_reg  <= held_new;
        end
    end

    // Select current state: forwarded write, stored entry, or reset value
    always_comb begin
        fwd_hit = fwd_valid_reg && (fwd_voice_reg == s1_voice_reg);
        if (fwd_hit) begin
            phase_cur = fwd_phase_reg;
            held_cur  = fwd_held_reg;
        end else if (written_rd_reg) begin
            phase_cur = phase_rd_reg;
            held_cur  = held_rd_reg;
        end else begin
            phase_cur = '0;
            held_cur  = '0;
        end
    end

    // Advance phase; a carry out clocks the LFSR and draws a new held value
    always_comb begin
        phase_sum = {1'b0, phase_cur} + {1'b0, phase_inc};
        wrap      = phase_sum[pvlfo_pkg::PHASE_W];
        lfsr_src  = (lfsr_reg == '0) ? pvlfo_pkg::LFSR_W'(1) : lfsr_reg;
        lfsr_step = {1'b0, lfsr_src[pvlfo_pkg::LFSR_W-1:1]}
                    ^ (lfsr_src[0] ? pvlfo_pkg::LFSR_TOGGLE : '0);
        held_new  = wrap ? lfsr_step[pvlfo_pkg::LFSR_W-1 -: pvlfo_pkg::SAMPLE_W] : held_cur;

        if (seed_load) begin
            lfsr_next = seed_value;
        end else if (s1_valid_reg && wrap) begin
            lfsr_next = lfsr_step;
        end else begin
            lfsr_next = lfsr_reg;
        end

        stage_next.valid = s1_valid_reg;
        stage_next.voice = s1_voice_reg;
        stage_next.phase = phase_sum[pvlfo_pkg::PHASE_W-1:0];
        stage_next.held  = held_new;
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/pvlfo_shaper.sv
// Waveform generation, level scaling, rounding, offset and Q1.15 saturation.
// Depends on pvlfo_pkg (stage types and sine table).
module pvlfo_shaper (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pvlfo_pkg::phase_stage_t   stage_in,
    input  pvlfo_pkg::shape_cfg_t     cfg,
    output logic                      res_valid,
    output pvlfo_pkg::result_t        res
);

    logic [pvlfo_pkg::PHASE_W-1:0]     p;
    logic [1:0]                        quad;
    logic [pvlfo_pkg::SINE_IDX_W-1:0]  sine_idx;
    logic [pvlfo_pkg::WAVE_W-1:0]      sine_mag;
    logic [pvlfo_pkg::PHASE_W-1:0]     tri_dist;
    logic signed [pvlfo_pkg::WAVE_W-1:0] wave_next;

    logic                              wave_valid_reg;
    logic [pvlfo_pkg::VOICE_W-1:0]     wave_voice_reg;
    logic signed [pvlfo_pkg::WAVE_W-1:0] wave_reg;

    logic                              prod_valid_reg;
    logic [pvlfo_pkg::VOICE_W-1:0]     prod_voice_reg;
    logic signed [2*pvlfo_pkg::WAVE_W-1:0] prod_reg;
    logic signed [2*pvlfo_pkg::WAVE_W-1:0] prod_next;

    logic signed [2*pvlfo_pkg::WAVE_W-1:0] prod_rnd;
    logic signed [2*pvlfo_pkg::WAVE_W-16:0] scaled;
    logic signed [2*pvlfo_pkg::WAVE_W-15:0] with_offset;
    logic [pvlfo_pkg::SAMPLE_W-1:0]    sat_value;

    // Form the raw wave from the top phase bits
    always_comb begin
        p        = stage_in.phase;
        quad     = p[pvlfo_pkg::PHASE_W-1 -: 2];
        sine_idx = p[pvlfo_pkg::PHASE_W-3 -: pvlfo_pkg::SINE_IDX_W];
        if (quad[0]) begin
            sine_idx = ~sine_idx;
        end
        sine_mag = pvlfo_pkg::WAVE_W'(pvlfo_pkg::SINE_ROM[sine_idx]);
        tri_dist = p[pvlfo_pkg::PHASE_W-1] ? {1'b0, p[pvlfo_pkg::PHASE_W-2:0]}
                                           : (32'h8000_0000 - p);

        case (cfg.waveform)
            pvlfo_pkg::WAVE_SINE:
                wave_next = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
            pvlfo_pkg::WAVE_TRIANGLE:
                wave_next = $signed(17'd32768 - tri_dist[pvlfo_pkg::PHASE_W-1:15]);
            pvlfo_pkg::WAVE_SAW_UP:
                wave_next = $signed({1'b0, p[pvlfo_pkg::PHASE_W-1 -: 16]} - 17'd32768);
            pvlfo_pkg::WAVE_SAW_DOWN:
                wave_next = $signed(17'd32768 - {1'b0, p[pvlfo_pkg::PHASE_W-1 -: 16]});
            pvlfo_pkg::WAVE_SQUARE:
                wave_next = p[pvlfo_pkg::PHASE_W-1] ? -17'sd32768 : 17'sd32768;
            pvlfo_pkg::WAVE_RANDOM:
                wave_next = $signed({stage_in.held[pvlfo_pkg::SAMPLE_W-1], stage_in.held});
            default:
                wave_next = '0;
        endcase
    end

    // Scale by level
    assign prod_next = wave_reg * $signed({1'b0, cfg.level});

    // Round half up, add offset, saturate
    always_comb begin
        prod_rnd    = prod_reg + 34'sd16384;
        scaled      = prod_rnd[2*pvlfo_pkg::WAVE_W-1:15];
        with_offset = $signed({scaled[2*pvlfo_pkg::WAVE_W-16], scaled})
                      + $signed(cfg.offset);
        if (with_offset > 20'sd32767) begin
            sat_value = 16'h7FFF;
        end else if (with_offset < -20'sd32768) begin
            sat_value = 16'h8000;
        end else begin
            sat_value = with_offset[pvlfo_pkg::SAMPLE_W-1:0];
        end
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wave_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            wave_valid_reg <= stage_in.valid;
            prod_valid_reg <= wave_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk) begin
        wave_voice_reg <= stage_in.voice;
        wave_reg       <= wave_next;
        prod_voice_reg <= wave_voice_reg;
        prod_reg       <= prod_next;
    end

    assign res_valid     = prod_valid_reg;
    assign res.voice     = prod_voice_reg;
    assign res.mod_value = sat_value;

endmodule

FILE: rtl/pvlfo_out_fifo.sv
// Output queue that decouples the sample pipeline from the result channel.
// Depends on pvlfo_pkg (result type and depth).
module pvlfo_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pvlfo_pkg::result_t   push_data,
    input  logic                 pop,
    output logic                 head_valid,
    output pvlfo_pkg::result_t   head_data
);

    pvlfo_pkg::result_t                entries [pvlfo_pkg::FIFO_DEPTH];
    logic [pvlfo_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [pvlfo_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [pvlfo_pkg::OCC_W-1:0]       count_reg;
    logic [pvlfo_pkg::OCC_W-1:0]       count_next;

    // Store incoming results
    always_ff @(posedge clk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_comb begin
        count_next = count_reg + pvlfo_pkg::OCC_W'(push) - pvlfo_pkg::OCC_W'(pop);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entries[rd_ptr_reg];

endmodule

FILE: rtl/per_voice_multi_wave_lfo_core.sv
// Top level of the per-voice multi-waveform LFO: configuration registers, flow control.
// Depends on pvlfo_pkg, pvlfo_state, pvlfo_shaper and pvlfo_out_fifo.
//
// One transaction on the input names a voice (0..15); the block returns one
// transaction with that voice and its signed Q1.15 modulation sample, in order.
// It takes a new voice every clock cycle; each one passes the memory read, state
// stage, wave and product registers and the output queue, and up to eight transactions
// may be outstanding before in_ready drops. The rate is set by the read-modify-write
// loop on the voice memory, which a one-entry forward path closes even when the same
// voice repeats back to back. Per-voice state resets to zero at once (no clearing pass).
// Configuration writes take effect on the next cycle and are meant for idle periods;
// writing the noise seed also reloads the shared noise generator.
module per_voice_multi_wave_lfo_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [pvlfo_pkg::VOICE_W-1:0]          voice,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [pvlfo_pkg::VOICE_W-1:0]          voice_out,
    output logic signed [pvlfo_pkg::SAMPLE_W-1:0]  mod_value,
    input  logic                                   cfg_write_en,
    input  logic [pvlfo_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pvlfo_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [pvlfo_pkg::PHASE_W-1:0]    phase_inc_reg;
    logic [pvlfo_pkg::WAVE_SEL_W-1:0] waveform_reg;
    logic [pvlfo_pkg::LEVEL_W-1:0]    level_reg;
    logic [pvlfo_pkg::SAMPLE_W-1:0]   offset_reg;
    logic [pvlfo_pkg::OCC_W-1:0]      occ_reg;
    logic [pvlfo_pkg::OCC_W-1:0]      occ_next;

    logic                             in_fire;
    logic                             out_fire;
    logic                             seed_load;
    pvlfo_pkg::phase_stage_t          ph_stage;
    pvlfo_pkg::shape_cfg_t            shape_cfg;
    logic                             res_valid;
    pvlfo_pkg::result_t               res;
    pvlfo_pkg::result_t               head;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign seed_load = cfg_write_en && (cfg_index == pvlfo_pkg::CFG_NOISE_SEED);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_inc_reg <= pvlfo_pkg::RST_PHASE_INC;
            waveform_reg  <= pvlfo_pkg::RST_WAVEFORM;
            level_reg     <= pvlfo_pkg::RST_LEVEL;
            offset_reg    <= pvlfo_pkg::RST_OFFSET;
        end else if (cfg_write_en) begin
            case (cfg_index)
                pvlfo_pkg::CFG_PHASE_INC:
                    phase_inc_reg <= cfg_data[pvlfo_pkg::PHASE_W-1:0];
                pvlfo_pkg::CFG_WAVEFORM:
                    waveform_reg <= cfg_data[pvlfo_pkg::WAVE_SEL_W-1:0];
                pvlfo_pkg::CFG_LEVEL:
                    level_reg <= cfg_data[pvlfo_pkg::LEVEL_W-1:0];
                pvlfo_pkg::CFG_OFFSET:
                    offset_reg <= cfg_data[pvlfo_pkg::SAMPLE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Count outstanding transactions; stop accepting when the queue could fill
    always_comb begin
        occ_next = occ_reg + pvlfo_pkg::OCC_W'(in_fire) - pvlfo_pkg::OCC_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign in_ready = (occ_reg < pvlfo_pkg::OCC_W'(pvlfo_pkg::FIFO_DEPTH));

    assign shape_cfg.waveform = waveform_reg;
    assign shape_cfg.level    = level_reg;
    assign shape_cfg.offset   = offset_reg;

    pvlfo_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_fire),
        .rd_voice   (voice),
        .phase_inc  (phase_inc_reg),
        .seed_load  (seed_load),
        .seed_value (cfg_data[pvlfo_pkg::LFSR_W-1:0]),
        .stage_out  (ph_stage)
    );

    pvlfo_shaper u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (ph_stage),
        .cfg       (shape_cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    pvlfo_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (out_fire),
        .head_valid (out_valid),
        .head_data  (head)
    );

    assign voice_out = head.voice;
    assign mod_value = head.mod_value;

`ifndef SYNTHESIS
    // Outstanding count never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= pvlfo_pkg::OCC_W'(pvlfo_pkg::FIFO_DEPTH))
        else $error("outstanding transaction count exceeds queue depth");

    // An accepted voice reaches the shaper through the memory read and state stage registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##2 ph_stage.valid)
        else $error("accepted transaction lost in state stage");

    // A shaper input reaches the queue push through the wave and product registers
    assert property (@(posedge clk) disable iff (!rst_n)
        ph_stage.valid |-> ##2 res_valid)
        else $error("shaper dropped a sample");

    // A result shown on the output is always counted as outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occ_reg != '0))
        else $error("output valid with no outstanding transaction");
`endif

endmodule
